// ===== design/lz4d_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4d_pkg
// Shared event and error codes and format constants for the LZ4 block decoder.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_FAIL  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
  localparam logic [2:0] ERR_OVERSIZE  = 3'd2;
  localparam logic [2:0] ERR_LIT_OVER  = 3'd3;
  localparam logic [2:0] ERR_BAD_DIST  = 3'd4;
  localparam logic [2:0] ERR_MAT_OVER  = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;
  localparam logic [2:0] ERR_BUSY      = 3'd7;

  localparam logic [3:0] NIB_EXT    = 4'hF;
  localparam logic [7:0] BYTE_EXT   = 8'hFF;
  localparam int         MIN_MATCH  = 4;

  // History window size; a power of two so that positions wrap by masking.
  localparam int         WINDOW_BYTES = 65536;

endpackage

// ===== design/lz4d_ifs.sv =====
// ----------------------------------------------------------------------------
// lz4d channel interfaces
// Valid/ready channels for feed items, result items and configuration.
// ----------------------------------------------------------------------------
interface lz4d_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, command, in_byte, last_byte, input ready);
  modport sink   (input valid, command, in_byte, last_byte, output ready);
endinterface

interface lz4d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  out_byte;
  logic        final_res;
  logic [31:0] decoded_count;
  logic [2:0]  error_code;
  modport source (output valid, event_res, out_byte, final_res, decoded_count, error_code,
                  input ready);
  modport sink   (input valid, event_res, out_byte, final_res, decoded_count, error_code,
                  output ready);
endinterface

interface lz4d_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/lz4d_history.sv =====
// ----------------------------------------------------------------------------
// lz4d_history
// History window: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lz4d_history #(
  parameter int WINDOW_BYTES = 65536,
  parameter int AW = $clog2(WINDOW_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [WINDOW_BYTES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lz4_block_decoder.sv =====
// ----------------------------------------------------------------------------
// lz4_block_decoder
// Streaming LZ4 block decoder with a size header and a history window.
//
//  Channel  Dir  Payload
//  feed     in   command, in_byte, last_byte
//  result   out  event_res, out_byte, final_res, decoded_count, error_code
//  cfg      in   data (output_capacity)
//
// One item is accepted per cycle unless the feed stalls; a result appears in the
// output register the cycle after its item. A copy byte is read from the history
// memory at acceptance and written back in the following cycle, with forwarding
// from that pending write. Reset is synchronous; the history needs no clearing.
// The feed channel stalls only while a result waits in the output register.
// ----------------------------------------------------------------------------
module lz4_block_decoder
  import lz4d_pkg::*;
#(
  parameter int HEADER_BYTES = 8,
  parameter int COUNT_BITS   = 32
) (
  input logic      clk,
  input logic      rst,
  lz4d_in_if.sink  feed,
  lz4d_out_if.source result,
  lz4d_cfg_if.sink cfg
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CB = COUNT_BITS;

  typedef enum logic [3:0] {
    PH_HEADER, PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_COPY, PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [7:0]  byte_v;
    logic        fin;
    logic [31:0] cnt;
    logic [2:0]  err;
  } res_t;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [7:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + (CB+1)'(b);
    return s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  // Decoder state.
  phase_t        phase, phase_next;
  logic [2:0]    hdr_idx, hdr_idx_next;
  logic [63:0]   orig, orig_next;
  logic [3:0]    tok_nib, tok_nib_next;
  logic [CB-1:0] lit_rem, lit_rem_next;
  logic [15:0]   mdist, mdist_next;
  logic [CB-1:0] mrem, mrem_next;
  logic [CB-1:0] bw, bw_next;
  logic          end_seen, end_seen_next;
  logic [31:0]   capacity;

  // Output register and copy write-back.
  logic          ov;
  res_t          ores;
  logic          opend;
  logic          cw_pend;
  logic [AW-1:0] cw_addr;
  logic          fwd_hit;
  logic [7:0]    fwd_byte;

  // Combinational results.
  logic          fire, r_valid, r_pend, lit_we;
  res_t          r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    mem_q, copy_byte;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign fire        = feed.valid & feed.ready;
  assign feed.ready  = ~ov | result.ready;
  assign cfg.ready   = 1'b1;
  assign copy_byte   = fwd_hit ? fwd_byte : mem_q;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 32'd65536;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // Next-state logic for one accepted item.
  always_comb begin
    logic b_last;
    logic do_fail, do_empty, lk, mk, do_close, close_last;
    logic [2:0] ferr;
    logic [7:0] b;
    b_last = feed.last_byte;
    b = feed.in_byte;
    phase_next = phase; hdr_idx_next = hdr_idx; orig_next = orig; tok_nib_next = tok_nib;
    lit_rem_next = lit_rem; mdist_next = mdist; mrem_next = mrem; bw_next = bw;
    end_seen_next = end_seen;
    do_fail = 1'b0; do_empty = 1'b0; lk = 1'b0; mk = 1'b0; ferr = ERR_NONE;
    do_close = 1'b0; close_last = b_last;
    r_valid = 1'b0; r_pend = 1'b0; lit_we = 1'b0; rd_en = 1'b0;
    rd_addr = bw[AW-1:0] - mdist[AW-1:0];
    r = '{ev: EV_BYTE, byte_v: 8'd0, fin: 1'b0, cnt: 32'(bw), err: ERR_NONE};

    if (feed.command) begin
      // Copy step.
      if (phase == PH_COPY) begin
        rd_en = 1'b1;
        r_valid = 1'b1;
        r_pend = 1'b1;
        bw_next = sat_add(bw, 8'd1);
        mrem_next = (mrem != '0) ? mrem - CB'(1) : mrem;
        r.cnt = 32'(bw_next);
        if (mrem_next == '0) begin
          if (end_seen || (64'(bw_next) == orig)) begin
            r.fin = 1'b1;
            do_close = 1'b1;
            close_last = end_seen;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          orig_next = orig | (64'(b) << {hdr_idx, 3'b000});
          if (({1'b0, hdr_idx} + 4'd1) < 4'(HEADER_BYTES)) begin
            hdr_idx_next = hdr_idx + 3'd1;
            if (b_last) begin do_fail = 1'b1; ferr = ERR_SHORT_HDR; end
          end else begin
            hdr_idx_next = 3'd0;
            if (b_last) begin
              do_fail = 1'b1; ferr = ERR_SHORT_HDR;
            end else if (orig_next > 64'(capacity)) begin
              do_fail = 1'b1; ferr = ERR_OVERSIZE;
            end else if (orig_next == 64'd0) begin
              do_empty = 1'b1;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          lit_rem_next = CB'(b[7:4]);
          tok_nib_next = b[3:0];
          if (b[7:4] == NIB_EXT) begin
            if (b_last) begin do_fail = 1'b1; ferr = ERR_TRUNC; end
            else phase_next = PH_LITEXT;
          end else begin
            lk = 1'b1;
          end
        end
        PH_LITEXT: begin
          lit_rem_next = sat_add(lit_rem, b);
          if (b == BYTE_EXT) begin
            if (b_last) begin do_fail = 1'b1; ferr = ERR_TRUNC; end
          end else begin
            lk = 1'b1;
          end
        end
        PH_LIT: begin
          if ((lit_rem > CB'(1)) && b_last) begin
            do_fail = 1'b1; ferr = ERR_TRUNC;
          end else begin
            lit_we = 1'b1;
            bw_next = sat_add(bw, 8'd1);
            lit_rem_next = (lit_rem != '0) ? lit_rem - CB'(1) : lit_rem;
            r_valid = 1'b1;
            r.byte_v = b;
            r.cnt = 32'(bw_next);
            if (lit_rem_next == '0) begin
              r.fin = b_last;
              if (b_last) do_close = 1'b1;
              else phase_next = PH_OFFLO;
            end
          end
        end
        PH_OFFLO: begin
          if (b_last) begin
            do_empty = 1'b1;
          end else begin
            mdist_next = {8'd0, b};
            phase_next = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          mdist_next = {b, mdist[7:0]};
          mrem_next = CB'(tok_nib) + CB'(MIN_MATCH);
          if (tok_nib == NIB_EXT) begin
            if (b_last) begin do_fail = 1'b1; ferr = ERR_TRUNC; end
            else phase_next = PH_MATEXT;
          end else begin
            mk = 1'b1;
          end
        end
        PH_MATEXT: begin
          mrem_next = sat_add(mrem, b);
          if (b == BYTE_EXT) begin
            if (b_last) begin do_fail = 1'b1; ferr = ERR_TRUNC; end
          end else begin
            mk = 1'b1;
          end
        end
        PH_COPY: begin
          do_fail = 1'b1; ferr = ERR_BUSY;
        end
        default: begin
          if (b_last) do_close = 1'b1;
        end
      endcase

      // Literal length known.
      if (lk) begin
        if (64'({1'b0, bw} + {1'b0, lit_rem_next}) > orig) begin
          do_fail = 1'b1; ferr = ERR_LIT_OVER;
        end else if (lit_rem_next == '0) begin
          if (b_last) do_empty = 1'b1;
          else phase_next = PH_OFFLO;
        end else if (b_last) begin
          do_fail = 1'b1; ferr = ERR_TRUNC;
        end else begin
          phase_next = PH_LIT;
        end
      end

      // Match length known.
      if (mk) begin
        if ((mdist_next == 16'd0) || (CB'(mdist_next) > bw) ||
            ({1'b0, mdist_next} > 17'(WINDOW_BYTES))) begin
          do_fail = 1'b1; ferr = ERR_BAD_DIST;
        end else if (64'({1'b0, bw} + {1'b0, mrem_next}) > orig) begin
          do_fail = 1'b1; ferr = ERR_MAT_OVER;
        end else begin
          end_seen_next = b_last;
          phase_next = PH_COPY;
        end
      end

      if (do_fail) begin
        r_valid = 1'b1; r.ev = EV_FAIL; r.err = ferr; do_close = 1'b1;
      end else if (do_empty) begin
        r_valid = 1'b1; r.ev = EV_EMPTY; do_close = 1'b1;
      end
    end

    // Block close: restart on the last byte, otherwise skip to it.
    if (do_close) begin
      if (close_last) begin
        phase_next = PH_HEADER; hdr_idx_next = 3'd0; orig_next = '0; tok_nib_next = '0;
        lit_rem_next = '0; mdist_next = '0; mrem_next = '0; bw_next = '0;
        end_seen_next = 1'b0;
      end else begin
        phase_next = PH_SKIP;
      end
    end
  end

  // History write: a copy write-back has priority over a literal.
  always_comb begin
    mem_we    = cw_pend | (fire & lit_we);
    mem_waddr = cw_pend ? cw_addr : bw[AW-1:0];
    mem_wdata = cw_pend ? copy_byte : feed.in_byte;
  end

  lz4d_history #(.WINDOW_BYTES(WINDOW_BYTES), .AW(AW)) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (fire & rd_en),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  // State, output register and copy write-back tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; hdr_idx <= '0; orig <= '0; tok_nib <= '0; lit_rem <= '0;
      mdist <= '0; mrem <= '0; bw <= '0; end_seen <= 1'b0;
      ov <= 1'b0; opend <= 1'b0; cw_pend <= 1'b0; fwd_hit <= 1'b0;
    end else begin
      cw_pend <= fire & rd_en;
      // A new result replaces the one leaving; otherwise the copy byte settles.
      if (fire && r_valid) begin
        ov    <= 1'b1;
        ores  <= r;
        opend <= r_pend;
      end else begin
        if (result.ready) ov <= 1'b0;
        if (cw_pend) begin
          opend <= 1'b0;
          ores.byte_v <= copy_byte;
        end
      end
      if (fire) begin
        phase <= phase_next; hdr_idx <= hdr_idx_next; orig <= orig_next;
        tok_nib <= tok_nib_next; lit_rem <= lit_rem_next; mdist <= mdist_next;
        mrem <= mrem_next; bw <= bw_next; end_seen <= end_seen_next;
        if (rd_en) begin
          cw_addr <= bw[AW-1:0];
          fwd_hit <= cw_pend && (rd_addr == cw_addr);
          fwd_byte <= copy_byte;
        end
      end
    end
  end

  assign result.valid         = ov;
  assign result.event_res     = ores.ev;
  assign result.out_byte      = opend ? copy_byte : ores.byte_v;
  assign result.final_res     = ores.fin;
  assign result.decoded_count = ores.cnt;
  assign result.error_code    = ores.err;

endmodule
